FILE: sv/vertex_weld_find_or_add_assert.svh
// Assertion macros shared by the vertex weld RTL.
`ifndef VERTEX_WELD_FIND_OR_ADD_ASSERT_SVH
`define VERTEX_WELD_FIND_OR_ADD_ASSERT_SVH

// Same-cycle implication, skipped while reset is high.
`define VWF_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, skipped while reset is high.
`define VWF_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/vwf_pkg.sv
// Types and constants shared by the vertex weld block.
`timescale 1ns / 1ps
`default_nettype none

package vwf_pkg;

  localparam int COORD_BITS       = 24;
  localparam int IDX_W            = 10;
  localparam int THR_W            = 40;
  localparam int DIST_W           = 64;
  localparam int DEFAULT_CAPACITY = 1024;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(105);

  localparam logic OP_FIND  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [DIST_W-1:0]            dist_t;

  typedef struct packed {
    logic   operation;
    coord_t x_coord;
    coord_t y_coord;
    coord_t z_coord;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0] point_index;
    logic             was_added;
    logic             table_full;
  } rsp_t;

  // Tag that travels with each stored point through the distance pipeline.
  typedef struct packed {
    logic valid;
    logic last;
  } scan_ctl_t;

endpackage

`default_nettype wire

FILE: sv/vwf_point_mem.sv
// Point store: one synchronous memory, one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module vwf_point_mem #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 72
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/vwf_dist_pipe.sv
// Four-stage squared-distance pipeline with 64-bit saturation.
`timescale 1ns / 1ps
`default_nettype none

module vwf_dist_pipe
  import vwf_pkg::*;
#(
  parameter int ADDR_W = 10
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire scan_ctl_t   in_ctl,
  input  wire logic [ADDR_W-1:0] in_idx,
  input  wire coord_t      pt_x,
  input  wire coord_t      pt_y,
  input  wire coord_t      pt_z,
  input  wire coord_t      probe_x,
  input  wire coord_t      probe_y,
  input  wire coord_t      probe_z,
  output scan_ctl_t        out_ctl,
  output logic [ADDR_W-1:0] out_idx,
  output dist_t            out_dist
);

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;

  function automatic dist_t sat_add(input dist_t a, input dist_t b);
    logic [DIST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DIST_W] ? '1 : s[DIST_W-1:0];
  endfunction

  function automatic logic [DIFF_W-1:0] abs_diff(input coord_t a, input coord_t b);
    logic signed [DIFF_W-1:0] d;
    d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
  endfunction

  coord_t pt   [3];
  coord_t prb  [3];

  scan_ctl_t          s1_ctl, s2_ctl, s3_ctl;
  logic [ADDR_W-1:0]  s1_idx, s2_idx, s3_idx;
  logic [DIFF_W-1:0]  s1_mag [3];
  dist_t              s2_sq  [3];
  dist_t              s3_sum_xy;
  dist_t              s3_sq_z;

  assign pt[0]  = pt_x;
  assign pt[1]  = pt_y;
  assign pt[2]  = pt_z;
  assign prb[0] = probe_x;
  assign prb[1] = probe_y;
  assign prb[2] = probe_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl  <= '0;
      s2_ctl  <= '0;
      s3_ctl  <= '0;
      out_ctl <= '0;
    end else begin
      s1_ctl  <= in_ctl;
      s2_ctl  <= s1_ctl;
      s3_ctl  <= s2_ctl;
      out_ctl <= s3_ctl;
    end
  end

  // Stage 1: per-axis magnitude of the difference.
  always_ff @(posedge clk) begin
    s1_idx <= in_idx;
    for (int a = 0; a < 3; a++) begin
      s1_mag[a] <= abs_diff(pt[a], prb[a]);
    end
  end

  // Stage 2: per-axis square, saturate above 32-bit magnitude.
  always_ff @(posedge clk) begin
    logic [PROD_W-1:0] prod;
    logic              big;
    s2_idx <= s1_idx;
    for (int a = 0; a < 3; a++) begin
      prod = s1_mag[a] * s1_mag[a];
      big  = |(PROD_W'(s1_mag[a]) >> 32);
      s2_sq[a] <= big ? '1 : DIST_W'(prod);
    end
  end

  // Stage 3 and 4: saturating sum.
  always_ff @(posedge clk) begin
    s3_idx    <= s2_idx;
    s3_sum_xy <= sat_add(s2_sq[0], s2_sq[1]);
    s3_sq_z   <= s2_sq[2];
    out_idx   <= s3_idx;
    out_dist  <= sat_add(s3_sum_xy, s3_sq_z);
  end

endmodule

`default_nettype wire

FILE: sv/vertex_weld_find_or_add.sv
// Top level of the vertex weld block: point table with nearest-match lookup.
//
// Usage: present a request and raise start; it is taken at a clock edge
// where start is high and busy is low. A clear request (operation = 1)
// empties the table and returns an all-zero result. A find request
// scans every stored point for the smallest squared distance (the
// earliest point wins a tie); a match within the threshold thr returns
// its index, otherwise the point is appended and its new index returned,
// or table_full is set when the table is already full.
// Order from the accepting edge: a clear shows in the next cycle, a find
// on an empty table goes straight to decide, a find over stored points
// passes the reads, memory, four distance stages, best update, decide.
// busy falls in the cycle the result shows, so the next request can be
// taken in that cycle. The result stays on result until the next one;
// done marks it, high for exactly one cycle; the receiver cannot stall it.
// Configuration: cfg_wr_en/cfg_wr_data write the 40-bit squared threshold;
// write it only while busy is low and no result is pending.
// Reset (rst, synchronous): empty table, threshold 105, no result pending.
// Stored coordinates are not cleared; entries at or above the point count
// are never read.
`timescale 1ns / 1ps
`default_nettype none

`include "vertex_weld_find_or_add_assert.svh"

module vertex_weld_find_or_add
  import vwf_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire req_t             request,
  output logic                  done,
  output rsp_t                  result,
  input  wire logic             cfg_wr_en,
  input  wire logic [THR_W-1:0] cfg_wr_data
);

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int DATA_W = 3 * COORD_BITS;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_DECIDE = 2'd3;

  logic [1:0]        state;
  logic [CNT_W-1:0]  count;
  logic [THR_W-1:0]  thr;
  req_t              probe;
  logic [ADDR_W-1:0] rd_addr;
  logic              found;
  dist_t             best_dist;
  logic [ADDR_W-1:0] best_idx;

  // Tag registered alongside the memory read data.
  scan_ctl_t         tag_ctl;
  logic [ADDR_W-1:0] tag_idx;

  logic [DATA_W-1:0] rd_data;
  scan_ctl_t         pipe_ctl;
  logic [ADDR_W-1:0] pipe_idx;
  dist_t             pipe_dist;

  logic issue_last;
  logic take_better;
  logic is_match;
  logic is_full;
  logic mem_wr_en;

  assign busy        = (state != ST_IDLE);
  assign issue_last  = ((CNT_W'(rd_addr) + CNT_W'(1)) == count);
  assign take_better = pipe_ctl.valid && (!found || (pipe_dist < best_dist));
  assign is_match    = found && (best_dist <= DIST_W'(thr));
  assign is_full     = (count == CNT_W'(CAPACITY));
  // Append only once the scan is over, so no read of this request overlaps it.
  assign mem_wr_en   = (state == ST_DECIDE) && !is_match && !is_full;

  vwf_point_mem #(
    .DEPTH  (CAPACITY),
    .ADDR_W (ADDR_W),
    .DATA_W (DATA_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (ADDR_W'(count)),
    .wr_data ({probe.z_coord, probe.y_coord, probe.x_coord}),
    .rd_en   (state == ST_SCAN),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  vwf_dist_pipe #(
    .ADDR_W (ADDR_W)
  ) u_dist (
    .clk      (clk),
    .rst      (rst),
    .in_ctl   (tag_ctl),
    .in_idx   (tag_idx),
    .pt_x     (rd_data[COORD_BITS-1:0]),
    .pt_y     (rd_data[2*COORD_BITS-1:COORD_BITS]),
    .pt_z     (rd_data[3*COORD_BITS-1:2*COORD_BITS]),
    .probe_x  (probe.x_coord),
    .probe_y  (probe.y_coord),
    .probe_z  (probe.z_coord),
    .out_ctl  (pipe_ctl),
    .out_idx  (pipe_idx),
    .out_dist (pipe_dist)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      thr     <= THR_RESET;
      done    <= 1'b0;
      found   <= 1'b0;
      tag_ctl <= '0;
    end else begin
      done    <= 1'b0;
      tag_ctl <= '0;

      if (cfg_wr_en) begin
        thr <= cfg_wr_data;
      end

      // Keep the running best; strict less-than keeps the earliest on a tie.
      if (take_better) begin
        best_dist <= pipe_dist;
        best_idx  <= pipe_idx;
        found     <= 1'b1;
      end

      case (state)
        ST_IDLE: begin
          if (start) begin
            probe <= request;
            if (request.operation == OP_CLEAR) begin
              count  <= '0;
              result <= '0;
              done   <= 1'b1;
            end else begin
              found   <= 1'b0;
              rd_addr <= '0;
              state   <= (count == '0) ? ST_DECIDE : ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          // Issue one read per cycle, tag it, advance.
          tag_ctl.valid <= 1'b1;
          tag_ctl.last  <= issue_last;
          tag_idx       <= rd_addr;
          rd_addr       <= rd_addr + ADDR_W'(1);
          if (issue_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (pipe_ctl.valid && pipe_ctl.last) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          done  <= 1'b1;
          state <= ST_IDLE;
          if (is_match) begin
            result.point_index <= IDX_W'(best_idx);
            result.was_added   <= 1'b0;
            result.table_full  <= 1'b0;
          end else if (is_full) begin
            result.point_index <= '0;
            result.was_added   <= 1'b0;
            result.table_full  <= 1'b1;
          end else begin
            result.point_index <= IDX_W'(count);
            result.was_added   <= 1'b1;
            result.table_full  <= 1'b0;
            count              <= count + CNT_W'(1);
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `VWF_ASSERT_NEXT(a_decide_then_done, clk, rst, state == ST_DECIDE, done && !busy, "decide must produce a result")
  `VWF_ASSERT_NOW(a_add_bumps_count, clk, rst, done && result.was_added, count == $past(count) + CNT_W'(1), "append must bump count")
  `VWF_ASSERT_NOW(a_full_means_full, clk, rst, done && result.table_full, count == CNT_W'(CAPACITY), "table_full with room left")
  `VWF_ASSERT_NOW(a_pipe_only_scanning, clk, rst, pipe_ctl.valid, state == ST_SCAN || state == ST_DRAIN, "distance out of scan")
  `VWF_ASSERT_NEXT(a_clear_empties, clk, rst, start && !busy && request.operation == OP_CLEAR, done && count == '0, "clear must empty the table")

endmodule

`default_nettype wire

FILE: tb/vertex_weld_find_or_add_check.sv
// Checker for the vertex weld block: predicts each result and compares it.
`timescale 1ns / 1ps

module vertex_weld_find_or_add_check
  import vwf_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  req_t             request,
  input  logic             done,
  input  rsp_t             result,
  input  logic             cfg_wr_en,
  input  logic [THR_W-1:0] cfg_wr_data,
  output int               outstanding,
  output int               failures,
  output int               checked
);

  coord_t           table_x [CAPACITY];
  coord_t           table_y [CAPACITY];
  coord_t           table_z [CAPACITY];
  int               point_total;
  logic [THR_W-1:0] match_thr;
  rsp_t             expected_rsp[$];
  int               fail_cnt;
  int               check_cnt;

  // Exact square of one axis difference. The sum over three 24-bit axes
  // stays below 2^51, so it never saturates.
  function automatic dist_t axis_sq(coord_t a, coord_t b);
    longint diff;
    diff = longint'(a) - longint'(b);
    return dist_t'(diff * diff);
  endfunction

  // Apply one request to the point table and return its result.
  function automatic rsp_t weld_lookup(req_t r);
    rsp_t  res;
    dist_t best;
    dist_t d;
    int    best_i;
    bit    hit;
    res    = '0;
    best   = '0;
    best_i = 0;
    hit    = 1'b0;
    if (r.operation == OP_CLEAR) begin
      point_total = 0;
      return res;
    end
    for (int i = 0; i < point_total; i++) begin
      d = axis_sq(table_x[i], r.x_coord) + axis_sq(table_y[i], r.y_coord)
          + axis_sq(table_z[i], r.z_coord);
      // strict compare keeps the earliest point on a tie
      if (!hit || d < best) begin
        best   = d;
        best_i = i;
        hit    = 1'b1;
      end
    end
    if (hit && best <= dist_t'(match_thr)) begin
      res.point_index = IDX_W'(best_i);
    end else if (point_total >= CAPACITY) begin
      res.table_full = 1'b1;
    end else begin
      table_x[point_total] = r.x_coord;
      table_y[point_total] = r.y_coord;
      table_z[point_total] = r.z_coord;
      res.point_index      = IDX_W'(point_total);
      res.was_added        = 1'b1;
      point_total++;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    rsp_t pred;
    if (rst) begin
      point_total = 0;
      match_thr   = THR_RESET;
      expected_rsp.delete();
    end else begin
      if (done) begin
        check_cnt++;
        if (expected_rsp.size() == 0) begin
          $error("result with no request outstanding: index %0d added %0b full %0b",
                 result.point_index, result.was_added, result.table_full);
          fail_cnt++;
        end else begin
          want = expected_rsp.pop_front();
          if (result.point_index !== want.point_index) begin
            $error("point_index: expected %0d, got %0d", want.point_index,
                   result.point_index);
            fail_cnt++;
          end
          if (result.was_added !== want.was_added) begin
            $error("was_added: expected %0b, got %0b", want.was_added, result.was_added);
            fail_cnt++;
          end
          if (result.table_full !== want.table_full) begin
            $error("table_full: expected %0b, got %0b", want.table_full,
                   result.table_full);
            fail_cnt++;
          end
        end
      end
      if (cfg_wr_en) begin
        match_thr = cfg_wr_data;
      end
      if (start && !busy) begin
        pred = weld_lookup(request);
        expected_rsp.insert(expected_rsp.size(), pred);
      end
    end
    outstanding <= expected_rsp.size();
    failures    <= fail_cnt;
    checked     <= check_cnt;
  end

  initial begin
    fail_cnt    = 0;
    check_cnt   = 0;
    point_total = 0;
    match_thr   = THR_RESET;
    outstanding = 0;
    failures    = 0;
    checked     = 0;
  end

endmodule

FILE: tb/vertex_weld_find_or_add_test.sv
// Testbench top for the vertex weld block: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module vertex_weld_find_or_add_test;
  import vwf_pkg::*;

  localparam int     RANDOM_TARGET = 500;
  localparam int     FILL_POINTS   = 48;
  // Longest quiet stretch: a full-table scan plus the sender's longest gap,
  // taken several times over.
  localparam int     WATCHDOG_LIMIT = 5000;
  localparam int     SETTLE_CYCLES  = 12;
  localparam coord_t C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam coord_t C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [THR_W-1:0] THR_ALL = {THR_W{1'b1}};

  logic             clk         = 1'b0;
  logic             rst         = 1'b1;
  logic             start       = 1'b0;
  req_t             request     = '0;
  logic             cfg_wr_en   = 1'b0;
  logic [THR_W-1:0] cfg_wr_data = '0;
  logic             busy;
  logic             done;
  rsp_t             result;

  int outstanding;
  int failures;
  int checked;

  // stimulus bookkeeping
  bit     sender_idles = 1'b1;
  int     n_sent       = 0;
  int     n_clear      = 0;
  int     n_thr        = 0;
  int     quiet_cycles = 0;
  req_t   sent_points[$];

  always #5 clk = ~clk;

  vertex_weld_find_or_add dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .request     (request),
    .done        (done),
    .result      (result),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  vertex_weld_find_or_add_check weld_check (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .request     (request),
    .done        (done),
    .result      (result),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .outstanding (outstanding),
    .failures    (failures),
    .checked     (checked)
  );

  // Watchdog: end the run if neither a request nor a result moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic req_t find_req(coord_t x, coord_t y, coord_t z);
    req_t r;
    r.operation = OP_FIND;
    r.x_coord   = x;
    r.y_coord   = y;
    r.z_coord   = z;
    return r;
  endfunction

  // Clear carries random coordinates; the block must ignore them.
  function automatic req_t clear_req();
    req_t r;
    r           = find_req(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
    r.operation = OP_CLEAR;
    return r;
  endfunction

  // Shift a coordinate by up to +/- span; wrap at the ends of the range is fine.
  function automatic coord_t nudge(coord_t base, int span);
    int off;
    off = $urandom_range(0, 2 * span) - span;
    return coord_t'(int'(base) + off);
  endfunction

  function automatic coord_t pick_extreme();
    case ($urandom_range(0, 4))
      0:       return C_MIN;
      1:       return C_MAX;
      2:       return '0;
      3:       return '1;
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Hold the request with start high until it is taken. Called at a clock
  // edge; the optional gap lowers start first, otherwise start stays high
  // straight into the next request.
  task automatic issue(input req_t r);
    int gap;
    gap = sender_idles ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    n_sent++;
    if (r.operation == OP_CLEAR) begin
      n_clear++;
      sent_points.delete();
    end else begin
      sent_points.insert(sent_points.size(), r);
    end
  endtask

  // Drop start and hold off until every predicted result has arrived.
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Write the threshold; only called right after wait_idle.
  task automatic set_threshold(input logic [THR_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    n_thr++;
  endtask

  // One find request built from the history of this table: near misses,
  // exact repeats, extremes, tight clusters and fresh points.
  task automatic random_find();
    req_t base;
    int   span;
    int   kind;
    kind = $urandom_range(0, 99);
    if (sent_points.size() != 0) begin
      base = sent_points[$urandom_range(0, sent_points.size() - 1)];
    end else begin
      base = find_req(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
    end
    case ($urandom_range(0, 4))
      0:       span = 3;
      1:       span = 15;
      2:       span = 255;
      3:       span = 4095;
      default: span = 1 << 20;
    endcase
    if (kind < 30) begin
      issue(find_req(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom)));
    end else if (kind < 70) begin
      issue(find_req(nudge(base.x_coord, span), nudge(base.y_coord, span),
                     nudge(base.z_coord, span)));
    end else if (kind < 80) begin
      issue(find_req(base.x_coord, base.y_coord, base.z_coord));
    end else if (kind < 90) begin
      issue(find_req(pick_extreme(), pick_extreme(), pick_extreme()));
    end else begin
      // small cluster around the origin: equal distances come up often here
      issue(find_req(nudge('0, 4), nudge('0, 4), nudge('0, 4)));
    end
  endtask

  initial begin
    req_t kept;
    int   phase_len;
    int   n_random;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part, starting with the reset threshold (105).
    issue(find_req('0, '0, '0));                // empty table: add at 0
    issue(find_req('0, '0, '0));                // exact match
    issue(find_req(coord_t'(10), '0, '0));      // distance 100, inside threshold
    issue(find_req('0, coord_t'(11), '0));      // distance 121, just outside: add
    issue(find_req(C_MAX, C_MAX, C_MAX));
    issue(find_req(C_MIN, C_MIN, C_MIN));
    issue(find_req(C_MIN, C_MAX, C_MIN));
    issue(find_req(C_MAX, C_MIN, C_MAX));
    issue(clear_req());
    issue(find_req(C_MAX, C_MIN, '0));          // first add after a clear

    // Build two points that sit at equal distance from a later probe.
    wait_idle();
    set_threshold('0);
    issue(clear_req());
    issue(find_req('0, '0, '0));
    issue(find_req(coord_t'(2), '0, '0));
    issue(find_req(coord_t'(1), '0, '0));       // threshold zero: add

    // Widest threshold: near probes match the closest stored point.
    wait_idle();
    set_threshold(THR_ALL);
    issue(find_req(coord_t'(1), coord_t'(1), '0));
    issue(find_req('1, '1, '1));
    issue(find_req(coord_t'(3), '0, '0));
    issue(find_req(C_MAX, C_MAX, C_MAX));       // far beyond 2^40: add
    issue(find_req(C_MIN, C_MIN, C_MIN));
    issue(clear_req());

    // Build a run of distinct points, then revisit one of them.
    wait_idle();
    set_threshold('0);
    issue(clear_req());
    kept = '0;
    for (int i = 0; i < FILL_POINTS; i++) begin
      issue(find_req(coord_t'(i), coord_t'($urandom), coord_t'($urandom)));
      if (i == FILL_POINTS / 2) begin
        kept = sent_points[$];
      end
    end
    issue(find_req(C_MIN, coord_t'($urandom), coord_t'($urandom)));  // add
    issue(kept);                                                      // exact hit
    issue(find_req(C_MAX, C_MAX, C_MAX));                             // add
    wait_idle();
    set_threshold(THR_ALL);
    issue(find_req(nudge(kept.x_coord, 100), nudge(kept.y_coord, 100),
                   nudge(kept.z_coord, 100)));
    issue(find_req(C_MIN, C_MIN, C_MIN));
    issue(clear_req());

    // Random part in phases, each under its own threshold and idling mode.
    n_random = 0;
    while (n_random < RANDOM_TARGET) begin
      wait_idle();
      case ($urandom_range(0, 5))
        0:       set_threshold('0);
        1:       set_threshold(THR_RESET);
        2:       set_threshold(THR_ALL);
        3:       set_threshold(THR_W'($urandom_range(0, 1 << 16)));
        4:       set_threshold(THR_W'({$urandom, $urandom}));
        default: set_threshold(THR_W'($urandom_range(0, 1 << 24)));
      endcase
      sender_idles = ($urandom_range(0, 3) != 0);
      phase_len    = $urandom_range(30, 70);
      for (int k = 0; k < phase_len && n_random < RANDOM_TARGET; k++) begin
        if ($urandom_range(0, 99) < 3) begin
          wait_idle();
        end
        if ($urandom_range(0, 99) < 4) begin
          issue(clear_req());
        end else begin
          random_find();
        end
        n_random++;
      end
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d requests (%0d clears) across %0d threshold settings, %0d results checked.",
             n_sent, n_clear, n_thr, checked);
    $display("Included ties, exact repeats, near misses and coordinate extremes.");
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/vwf_pkg.sv
sv/vwf_point_mem.sv
sv/vwf_dist_pipe.sv
sv/vertex_weld_find_or_add.sv
tb/vertex_weld_find_or_add_check.sv
tb/vertex_weld_find_or_add_test.sv
